@@ hdl/qtu_pkg.sv @@
// ----------------------------------------------------------------------------
// qtu_pkg: shared types and constants for the quoted token unescaper
// Character codes, UTF-8 lead and trail marks and the job record that
// passes from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package qtu_pkg;

  localparam int QTU_FIFO_DEPTH = 4;   // default depth of the job queue

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_TRAIL = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3F;

  // Result bytes caused by one input byte (one to three), sent in order d0..d2.
  typedef struct packed {
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] cnt;      // number of results, 1 to 3
    logic       is_str;   // field type at the time of the byte
    logic       fend;     // last result is the end-of-field marker
  } qtu_job_t;

endpackage

@@ hdl/qtu_if.sv @@
// ----------------------------------------------------------------------------
// qtu_in_if / qtu_out_if: valid/ready channels of the unescaper
// A transfer takes place at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface qtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface qtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_string;
  logic       field_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_string,
                  output field_end, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_string,
                  input field_end, input last_of_run, output ready);
endinterface

@@ hdl/qtu_front.sv @@
// ----------------------------------------------------------------------------
// qtu_front: byte classifier and escape state
// Takes one byte per transfer, updates the quote/escape/hex state and
// pushes a job with the one to three result bytes that the byte causes.
// ----------------------------------------------------------------------------
module qtu_front
  import qtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  qtu_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output qtu_job_t   q_job
);

  logic        at_start_r,  at_start_nxt;
  logic        str_type_r,  str_type_nxt;
  logic        in_quotes_r, in_quotes_nxt;
  logic        esc_r,       esc_nxt;
  logic [2:0]  hex_cnt_r,   hex_cnt_nxt;
  logic [15:0] hex_val_r,   hex_val_nxt;
  logic        hex_stop_r,  hex_stop_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        is_ws;
  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [15:0] hv;
  // plain-byte outcome
  logic        p_end, p_quote, p_bs;
  logic        end_fld;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign c           = in_ch.in_byte;

  always_comb begin
    is_ws = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_dig = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      hex_dig = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      hex_dig = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
    p_end   = (c == CH_NUL) || (is_ws && !in_quotes_r);
    p_quote = (c == CH_QUOTE);
    p_bs    = (c == CH_BSLASH);
  end

  always_comb begin
    at_start_nxt  = at_start_r;
    str_type_nxt  = str_type_r;
    in_quotes_nxt = in_quotes_r;
    esc_nxt       = esc_r;
    hex_cnt_nxt   = hex_cnt_r;
    hex_val_nxt   = hex_val_r;
    hex_stop_nxt  = hex_stop_r;
    q_job         = '0;
    end_fld       = 1'b0;
    hv            = hex_val_r;

    if (at_start_r) begin
      str_type_nxt = (c == CH_QUOTE);
      at_start_nxt = 1'b0;
    end
    q_job.is_str = str_type_nxt;

    if (hex_cnt_r != 3'd0) begin
      if (c == CH_NUL) begin
        end_fld     = 1'b1;
        q_job.cnt   = 2'd1;
        q_job.d0    = CH_NUL;
      end else begin
        if (!hex_stop_r && hex_ok) begin
          hv = {hex_val_r[11:0], hex_dig};
        end else begin
          hex_stop_nxt = 1'b1;
        end
        hex_val_nxt = hv;
        hex_cnt_nxt = hex_cnt_r - 3'd1;
        if (hex_cnt_r == 3'd1) begin
          hex_val_nxt  = '0;
          hex_stop_nxt = 1'b0;
          if (hv <= UTF8_MAX1) begin
            q_job.cnt = 2'd1;
            q_job.d0  = hv[7:0];
          end else if (hv <= UTF8_MAX2) begin
            q_job.cnt = 2'd2;
            q_job.d0  = UTF8_LEAD2 | {3'b000, hv[10:6]};
            q_job.d1  = UTF8_TRAIL | {2'b00, hv[5:0] & UTF8_MASK};
          end else begin
            q_job.cnt = 2'd3;
            q_job.d0  = UTF8_LEAD3 | {4'b0000, hv[15:12]};
            q_job.d1  = UTF8_TRAIL | {2'b00, hv[11:6] & UTF8_MASK};
            q_job.d2  = UTF8_TRAIL | {2'b00, hv[5:0] & UTF8_MASK};
          end
        end
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (c == CH_BSLASH || c == CH_QUOTE) begin
        q_job.cnt = 2'd1;
        q_job.d0  = c;
      end else if (c == CH_LOW_U) begin
        hex_cnt_nxt  = 3'd4;
        hex_val_nxt  = '0;
        hex_stop_nxt = 1'b0;
      end else begin
        // lone backslash goes out, then the byte is handled as plain
        q_job.d0 = CH_BSLASH;
        if (p_end) begin
          end_fld   = 1'b1;
          q_job.cnt = 2'd2;
          q_job.d1  = CH_NUL;
        end else if (p_quote) begin
          in_quotes_nxt = !in_quotes_r;
          q_job.cnt     = 2'd1;
        end else if (p_bs) begin
          esc_nxt   = 1'b1;
          q_job.cnt = 2'd1;
        end else begin
          q_job.cnt = 2'd2;
          q_job.d1  = c;
        end
      end
    end else begin
      if (p_end) begin
        end_fld   = 1'b1;
        q_job.cnt = 2'd1;
        q_job.d0  = CH_NUL;
      end else if (p_quote) begin
        in_quotes_nxt = !in_quotes_r;
      end else if (p_bs) begin
        esc_nxt = 1'b1;
      end else begin
        q_job.cnt = 2'd1;
        q_job.d0  = c;
      end
    end

    q_job.fend = end_fld;
    if (end_fld) begin
      at_start_nxt  = 1'b1;
      str_type_nxt  = 1'b0;
      in_quotes_nxt = 1'b0;
      esc_nxt       = 1'b0;
      hex_cnt_nxt   = '0;
      hex_val_nxt   = '0;
      hex_stop_nxt  = 1'b0;
    end
  end

  assign q_push = accept && (q_job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      str_type_r  <= 1'b0;
      in_quotes_r <= 1'b0;
      esc_r       <= 1'b0;
      hex_cnt_r   <= '0;
      hex_val_r   <= '0;
      hex_stop_r  <= 1'b0;
    end else if (accept) begin
      at_start_r  <= at_start_nxt;
      str_type_r  <= str_type_nxt;
      in_quotes_r <= in_quotes_nxt;
      esc_r       <= esc_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      hex_val_r   <= hex_val_nxt;
      hex_stop_r  <= hex_stop_nxt;
    end
  end

endmodule

@@ hdl/qtu_fifo.sv @@
// ----------------------------------------------------------------------------
// qtu_fifo: job queue between front and back end
// Small circular buffer, one push and one pop per cycle; a push is ignored while full and a pop while empty.
// ----------------------------------------------------------------------------
module qtu_fifo
  import qtu_pkg::*;
#(
  parameter int DEPTH = QTU_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  qtu_job_t push_job,
  output logic     full,
  input  logic     pop,
  output qtu_job_t pop_job,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qtu_job_t      mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/qtu_back.sv @@
// ----------------------------------------------------------------------------
// qtu_back: result serialiser
// Walks the head job's bytes into a registered output stage, one result per
// cycle while the output is not stalled; pops the job with its last result.
// ----------------------------------------------------------------------------
module qtu_back
  import qtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qtu_job_t   q_job,
  input  logic       q_empty,
  output logic       q_pop,
  qtu_out_if.source  out_ch
);

  logic [1:0] idx_r,       idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r,  out_byte_nxt;
  logic       is_str_r,    is_str_nxt;
  logic       fend_r,      fend_nxt;
  logic       last_r,      last_nxt;
  logic       load;
  logic       is_last;

  assign load    = !q_empty && (!out_valid_r || out_ch.ready);
  assign is_last = (idx_r == q_job.cnt - 2'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    is_str_nxt    = is_str_r;
    fend_nxt      = fend_r;
    last_nxt      = last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      is_str_nxt    = q_job.is_str;
      last_nxt      = is_last;
      fend_nxt      = q_job.fend && is_last;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
      case (idx_r)
        2'd0:    out_byte_nxt = q_job.d0;
        2'd1:    out_byte_nxt = q_job.d1;
        default: out_byte_nxt = q_job.d2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    is_str_r   <= is_str_nxt;
    fend_r     <= fend_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.is_string   = is_str_r;
  assign out_ch.field_end   = fend_r;
  assign out_ch.last_of_run = last_r;

endmodule

@@ hdl/quoted_token_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// quoted_token_unescape_utf8: quoted token unescaper with UTF-8 output
// Top level: front end, job queue and back end.
// ----------------------------------------------------------------------------
// Takes a text field one byte per transfer and returns the decoded bytes.
// The first byte of a field sets its type (double quote: string, else
// integer). Unescaped quotes toggle the inside-quotes flag and give no
// result; \\ and \" give the second character; \uXXXX gives the value of
// its leading hex digits as one to three UTF-8 bytes; a backslash before
// anything else is passed on and the byte is then handled normally. A zero
// byte, or whitespace outside quotes, closes the field with a marker result
// (out_byte 0, field_end 1). last_of_run flags the final result of each
// input byte. Timing: the front end takes one byte every cycle while the
// job queue (FIFO_DEPTH entries) is not full, and a byte's job is written
// into the queue at its own transfer edge; the back end sends one result
// per cycle from a registered output stage while the receiver is ready,
// so bytes with at most one result then sustain one per cycle. The back
// end loads the first result from the queue into the output register,
// where it is offered until the receiver takes it.
// ----------------------------------------------------------------------------
module quoted_token_unescape_utf8
  import qtu_pkg::*;
#(
  parameter int FIFO_DEPTH = QTU_FIFO_DEPTH   // job queue entries, 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  qtu_in_if.sink     in_ch,
  qtu_out_if.source  out_ch
);

  qtu_job_t push_job;
  qtu_job_t head_job;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  // front end: classifies each byte, holds quote/escape/hex state
  qtu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // decouples the byte rate from the result rate
  qtu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (head_job),
    .empty    (q_empty)
  );

  // back end: one result per cycle into the output register while not stalled
  qtu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hdl/qtu_checker.sv @@
// ----------------------------------------------------------------------------
// qtu_checker: port-level assertions for the unescaper
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module qtu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_string,
  input logic       field_end,
  input logic       last_of_run
);

  logic       xfer;
  logic       mid_run_r;
  logic       run_str_r;
  logic [1:0] run_len_r;

  assign xfer = out_valid && out_ready;

  // track the results of one input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_run_r <= 1'b0;
      run_str_r <= 1'b0;
      run_len_r <= '0;
    end else if (xfer) begin
      mid_run_r <= !last_of_run;
      run_str_r <= is_string;
      run_len_r <= last_of_run ? 2'd0 : run_len_r + 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result changed while stalled");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_end |-> out_byte == 8'h00 && last_of_run)
    else $error("field end marker malformed");

  a_run_type: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && mid_run_r |-> is_string == run_str_r)
    else $error("field type changed within one run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && run_len_r == 2'd2 |-> last_of_run)
    else $error("more than three results for one byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quoted_token_unescape_utf8 qtu_checker u_qtu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .is_string   (out_ch.is_string),
  .field_end   (out_ch.field_end),
  .last_of_run (out_ch.last_of_run)
);

@@ verif/qtu_decode_checker.sv @@
// ----------------------------------------------------------------------------
// qtu_decode_checker: predicts and checks the unescaper's decoded bytes
// Watches both channels. Each input transfer runs the field decoder below
// and queues the bytes it should produce; each result transfer is matched
// field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
module qtu_decode_checker
  import qtu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qtu_in_if    in_ch,
  qtu_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_str;
    logic       fend;
    logic       last;
  } decoded_t;

  decoded_t decoded_q[$];   // bytes still owed by the block, oldest first
  decoded_t char_run[$];    // bytes caused by the character being decoded
  int       tally;

  // decoder state
  logic        at_start;
  logic        str_type;
  logic        in_quotes;
  logic        esc_pend;
  logic [2:0]  hex_left;
  logic [15:0] hex_acc;
  logic        hex_halt;

  initial begin
    tally       = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);        // 0-9
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;   // a-f
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;   // A-F
    return -1;
  endfunction

  task automatic report_mismatch(input string msg);
    tally++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_state();
    at_start  = 1'b1;
    str_type  = 1'b0;
    in_quotes = 1'b0;
    esc_pend  = 1'b0;
    hex_left  = '0;
    hex_acc   = '0;
    hex_halt  = 1'b0;
  endtask

  task automatic put_decoded(input logic [7:0] d, input logic fe);
    decoded_t r;
    r.data   = d;
    r.is_str = str_type;
    r.fend   = fe;
    r.last   = 1'b0;
    char_run.push_back(r);
  endtask

  task automatic close_field();
    put_decoded(CH_NUL, 1'b1);
    clear_state();
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == CH_NUL || (is_blank(c) && !in_quotes)) close_field();
    else if (c == CH_QUOTE) in_quotes = ~in_quotes;
    else if (c == CH_BSLASH) esc_pend = 1'b1;
    else put_decoded(c, 1'b0);
  endtask

  task automatic decode_char(input logic [7:0] c);
    int          d;
    logic [15:0] v;
    char_run.delete();
    if (at_start) begin
      str_type = (c == CH_QUOTE);
      at_start = 1'b0;
    end
    if (hex_left != 0) begin
      if (c == CH_NUL) begin
        close_field();   // partial \u is dropped
      end else begin
        d = hex_digit(c);
        if (!hex_halt && d >= 0) hex_acc = {hex_acc[11:0], d[3:0]};
        else hex_halt = 1'b1;
        hex_left = hex_left - 3'd1;
        if (hex_left == 0) begin
          v = hex_acc;
          if (v <= UTF8_MAX1) begin
            put_decoded(v[7:0], 1'b0);
          end else if (v <= UTF8_MAX2) begin
            put_decoded(UTF8_LEAD2 | {3'b000, v[10:6]}, 1'b0);
            put_decoded(UTF8_TRAIL | {2'b00, v[5:0] & UTF8_MASK}, 1'b0);
          end else begin
            put_decoded(UTF8_LEAD3 | {4'h0, v[15:12]}, 1'b0);
            put_decoded(UTF8_TRAIL | {2'b00, v[11:6] & UTF8_MASK}, 1'b0);
            put_decoded(UTF8_TRAIL | {2'b00, v[5:0] & UTF8_MASK}, 1'b0);
          end
          hex_acc  = '0;
          hex_halt = 1'b0;
        end
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      if (c == CH_BSLASH || c == CH_QUOTE) begin
        put_decoded(c, 1'b0);
      end else if (c == CH_LOW_U) begin
        hex_left = 3'd4;
        hex_acc  = '0;
        hex_halt = 1'b0;
      end else begin
        put_decoded(CH_BSLASH, 1'b0);
        plain_char(c);
      end
    end else begin
      plain_char(c);
    end
    if (char_run.size() > 0) char_run[char_run.size() - 1].last = 1'b1;
    foreach (char_run[i]) decoded_q.push_back(char_run[i]);
  endtask

  task automatic check_result();
    decoded_t want;
    string    diffs;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: out_byte %02h field_end %b",
                                out_ch.out_byte, out_ch.field_end));
      return;
    end
    want  = decoded_q.pop_front();
    diffs = "";
    if (out_ch.out_byte !== want.data)
      diffs = {diffs, $sformatf(" out_byte %02h/%02h", out_ch.out_byte, want.data)};
    if (out_ch.is_string !== want.is_str)
      diffs = {diffs, $sformatf(" is_string %b/%b", out_ch.is_string, want.is_str)};
    if (out_ch.field_end !== want.fend)
      diffs = {diffs, $sformatf(" field_end %b/%b", out_ch.field_end, want.fend)};
    if (out_ch.last_of_run !== want.last)
      diffs = {diffs, $sformatf(" last_of_run %b/%b", out_ch.last_of_run, want.last)};
    if (diffs != "") report_mismatch({"result differs (got/exp):", diffs});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_q.delete();
    end else begin
      // a result can never stem from an input taken at the same edge
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) decode_char(in_ch.in_byte);
    end
    outstanding <= decoded_q.size();
    mismatches  <= tally;
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the quoted token unescaper
// Drives text fields into the block, stalls the result side at random and
// leaves prediction and checking of the decoded bytes to qtu_decode_checker.
// ----------------------------------------------------------------------------
module tb
  import qtu_pkg::*;
();

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   chars_sent;
  bit   calm;         // set: neither side idles

  qtu_in_if  in_if ();
  qtu_out_if out_if ();

  quoted_token_unescape_utf8 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  qtu_decode_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: reports FAIL and ends a run that hangs.
  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

  // One character per transfer. Random idle cycles in front of each one,
  // except in the calm stretch. valid stays high across back-to-back
  // transfers, so it is only ever assigned once per edge.
  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= c;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    chars_sent++;
    if (chars_sent == 200) calm = 1'b1;
    if (chars_sent == 330) calm = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // space, or one of tab / LF / VT / FF / CR
  task automatic send_blank();
    int k;
    k = $urandom_range(5);
    send_char((k == 5) ? CH_SPACE : CH_TAB + k[7:0]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  // \uXXXX with a value aimed at the one-, two- or three-byte UTF-8 range.
  // Now and then one of the four is spoilt: a zero (cuts the field short)
  // or an arbitrary byte (usually stops the digit run).
  task automatic send_hex_escape();
    logic [15:0] v;
    int          spoil;
    send_char(CH_BSLASH);
    send_char(CH_LOW_U);
    case ($urandom_range(2))
      0:       v = 16'($urandom_range(16'h007F, 16'h0000));
      1:       v = 16'($urandom_range(16'h07FF, 16'h0080));
      default: v = 16'($urandom_range(16'hFFFF, 16'h0800));
    endcase
    spoil = ($urandom_range(4) == 0) ? $urandom_range(3) : -1;
    for (int k = 0; k < 4; k++) begin
      if (k == spoil)
        send_char(($urandom_range(3) == 0) ? CH_NUL : 8'($urandom_range(255)));
      else
        send_char(hex_char(v[15 - 4*k -: 4], 1'($urandom_range(1))));
    end
  endtask

  // A mostly well-formed field: optional opening quote, a handful of
  // tokens, optional closing quote, then a zero or whitespace terminator.
  task automatic send_field();
    bit quoted;
    int n_tok;
    quoted = $urandom_range(99) < 60;
    if (quoted) send_char(CH_QUOTE);
    else if ($urandom_range(9) != 0)
      send_char(($urandom_range(9) < 7) ? 8'($urandom_range(8'h39, 8'h30))
                                        : 8'($urandom_range(255)));
    n_tok = $urandom_range(8);
    repeat (n_tok) begin
      case ($urandom_range(9))
        0, 1, 2: send_char(8'($urandom_range(8'h7E, 8'h21)));   // printable
        3: begin
          send_char(CH_BSLASH);
          send_char($urandom_range(1) ? CH_BSLASH : CH_QUOTE);
        end
        4, 5: send_hex_escape();
        6: begin
          // backslash before anything at all, zero and blanks included
          send_char(CH_BSLASH);
          send_char(8'($urandom_range(255)));
        end
        7:       send_char(CH_QUOTE);
        8:       send_blank();
        default: send_char(8'($urandom_range(255)));            // noise
      endcase
    end
    if (quoted && $urandom_range(99) < 85) send_char(CH_QUOTE);
    if ($urandom_range(3) == 0) send_char(CH_NUL);
    else send_blank();
  endtask

  // Receiver: random back-pressure, plus one long hold-off early in the
  // random part so the job queue fills and the input side stalls.
  initial begin
    int cyc;
    cyc = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 120 && cyc < 200) out_if.ready <= 1'b0;
      else out_if.ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  // Stimulus and verdict.
  initial begin
    chars_sent    = 0;
    calm          = 1'b0;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // String field: escaped backslash and quote, \uFFFF (largest three-byte
    // value), closing quote, ended by a zero.
    send_text("\"\\\\\\\"\\uFFFF\"");
    send_char(CH_NUL);
    // Integer field: \u with a non-hex fourth byte (value 7FF, top of the
    // two-byte range), then a backslash before a blank, which passes the
    // backslash on and closes the field.
    send_text("1\\u7FFg\\ ");
    // Empty fields, from a zero and from a carriage return.
    send_char(CH_NUL);
    send_char(CH_CR);
    // Top byte value starts an integer field; a zero in the middle of
    // the hex digits ends it with the marker alone.
    send_char(8'hFF);
    send_text("\\u1");
    send_char(CH_NUL);

    while (chars_sent < 530) send_field();
    in_if.valid <= 1'b0;

    // drain: wait for every queued byte, then wait on to catch strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
